// ===== design/svpwm_pkg.sv =====
// shared constants, types and sector codes for the space vector pwm timing pipeline
package svpwm_pkg;

    localparam int CompWidth   = 16;
    localparam int PeriodWidth = 16;
    localparam int SectorWidth = 3;
    localparam int NumStages   = 7;

    // alpha is scaled by 2^16 to line up with the q0.16 constants
    localparam int AlphaShift = 16;
    localparam int ProdShift  = CompWidth + 15;

    localparam int SumWidth  = CompWidth + 18;
    localparam int MagWidth  = SumWidth - 1;
    localparam int ProdWidth = MagWidth + PeriodWidth;
    localparam int TMagWidth = ProdWidth - ProdShift;
    localparam int TWidth    = TMagWidth + 1;
    localparam int DWidth    = TWidth + 2;

    localparam int InDataWidth  = ((2 * CompWidth + 7) / 8) * 8;
    localparam int OutDataWidth = ((3 * PeriodWidth + SectorWidth + 7) / 8) * 8;

    localparam logic [PeriodWidth-1:0] HalfPeriodReset = PeriodWidth'(10000);

    // 1/sqrt3 in q0.16 and 2/sqrt3 in q1.16
    localparam logic signed [SumWidth-1:0] KInvSqrt3    = SumWidth'(37837);
    localparam logic signed [SumWidth-1:0] KTwoInvSqrt3 = SumWidth'(75674);

    typedef logic signed [SumWidth-1:0] sum_t;
    typedef logic signed [TWidth-1:0]   ontime_t;
    typedef logic signed [DWidth-1:0]   diff_t;
    typedef logic [PeriodWidth-1:0]     period_t;

    typedef enum logic [SectorWidth-1:0] {
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5,
        SECTOR_6 = 3'd6
    } sector_t;

    // per-stage load strobes of the pipeline
    typedef struct packed {
        logic load_s1;
        logic load_s2;
        logic load_s3;
        logic load_s4;
        logic load_s5;
        logic load_s6;
        logic load_s7;
    } pipe_ctl_t;

endpackage

// ===== design/svpwm_sector.sv =====
// stages one and two: beta constant products, sector decision and on-time sum selection
module svpwm_sector
    import svpwm_pkg::*;
(
    input  logic                 clk,
    input  pipe_ctl_t            ctl,
    input  logic [CompWidth-1:0] alpha_in,
    input  logic [CompWidth-1:0] beta_in,
    output sum_t                 x_sum,
    output sum_t                 y_sum,
    output sector_t              sector
);

    sum_t    alpha_ext;
    sum_t    beta_ext;
    sum_t    a_reg;
    sum_t    a_next;
    sum_t    b1_reg;
    sum_t    b1_next;
    sum_t    b2_reg;
    sum_t    b2_next;

    sum_t    neg_b1;
    logic    gt_pos;
    logic    gt_neg;
    sector_t sector_next;
    sector_t sector_reg;
    sum_t    x_next;
    sum_t    x_reg;
    sum_t    y_next;
    sum_t    y_reg;

    // stage one
    assign alpha_ext = SumWidth'($signed(alpha_in));
    assign beta_ext  = SumWidth'($signed(beta_in));
    assign a_next    = alpha_ext <<< AlphaShift;
    assign b1_next   = beta_ext * KInvSqrt3;
    assign b2_next   = beta_ext * KTwoInvSqrt3;

    always_ff @(posedge clk)
    begin
        if (ctl.load_s1)
        begin
            a_reg  <= a_next;
            b1_reg <= b1_next;
            b2_reg <= b2_next;
        end
    end

    // stage two
    assign neg_b1 = -b1_reg;
    assign gt_pos = b1_reg > a_reg;
    assign gt_neg = neg_b1 > a_reg;

    always_comb
    begin
        priority if (!b1_reg[SumWidth-1] && !a_reg[SumWidth-1])
            sector_next = gt_pos ? SECTOR_2 : SECTOR_1;
        else if (!b1_reg[SumWidth-1])
            sector_next = gt_neg ? SECTOR_3 : SECTOR_2;
        else if (!a_reg[SumWidth-1])
            sector_next = gt_neg ? SECTOR_5 : SECTOR_6;
        else
            sector_next = gt_pos ? SECTOR_4 : SECTOR_5;
    end

    always_comb
    begin
        unique case (sector_next)
            SECTOR_1:
            begin
                x_next = a_reg - b1_reg;
                y_next = b2_reg;
            end
            SECTOR_2:
            begin
                x_next = b1_reg - a_reg;
                y_next = a_reg + b1_reg;
            end
            SECTOR_3:
            begin
                x_next = b2_reg;
                y_next = neg_b1 - a_reg;
            end
            SECTOR_4:
            begin
                x_next = -b2_reg;
                y_next = b1_reg - a_reg;
            end
            SECTOR_5:
            begin
                x_next = neg_b1 - a_reg;
                y_next = a_reg - b1_reg;
            end
            default:
            begin
                x_next = a_reg + b1_reg;
                y_next = -b2_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_s2)
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            sector_reg <= sector_next;
        end
    end

    assign x_sum  = x_reg;
    assign y_sum  = y_reg;
    assign sector = sector_reg;

endmodule

// ===== design/svpwm_ontime.sv =====
// stages three to five: magnitude, product with half period, shift and sign restore
module svpwm_ontime
    import svpwm_pkg::*;
(
    input  logic      clk,
    input  pipe_ctl_t ctl,
    input  sum_t      sum_in,
    input  period_t   half_period,
    output ontime_t   t_out
);

    sum_t                  sum_abs;
    logic [MagWidth-1:0]   mag_reg;
    logic                  neg3_reg;
    logic [ProdWidth-1:0]  prod_next;
    logic [ProdWidth-1:0]  prod_reg;
    logic                  neg4_reg;
    logic [TMagWidth-1:0]  tmag;
    ontime_t               tpos;
    ontime_t               t_next;
    ontime_t               t_reg;

    // stage three
    assign sum_abs = sum_in[SumWidth-1] ? -sum_in : sum_in;

    always_ff @(posedge clk)
    begin
        if (ctl.load_s3)
        begin
            mag_reg  <= sum_abs[MagWidth-1:0];
            neg3_reg <= sum_in[SumWidth-1];
        end
    end

    // stage four
    assign prod_next = ProdWidth'(mag_reg) * ProdWidth'(half_period);

    always_ff @(posedge clk)
    begin
        if (ctl.load_s4)
        begin
            prod_reg <= prod_next;
            neg4_reg <= neg3_reg;
        end
    end

    // stage five, magnitude truncated so the signed value rounds toward zero
    assign tmag   = prod_reg[ProdWidth-1:ProdShift];
    assign tpos   = ontime_t'({1'b0, tmag});
    assign t_next = neg4_reg ? -tpos : tpos;

    always_ff @(posedge clk)
    begin
        if (ctl.load_s5)
            t_reg <= t_next;
    end

    assign t_out = t_reg;

endmodule

// ===== design/svpwm_phase.sv =====
// stages six and seven: base time, phase sums, clamping and routing by sector
module svpwm_phase
    import svpwm_pkg::*;
(
    input  logic      clk,
    input  pipe_ctl_t ctl,
    input  ontime_t   tx,
    input  ontime_t   ty,
    input  sector_t   sector_in,
    input  period_t   half_period,
    output period_t   duty_a,
    output period_t   duty_b,
    output period_t   duty_c,
    output sector_t   sector
);

    diff_t   hp_ext;
    diff_t   diff;
    diff_t   diff_adj;
    diff_t   base_reg;
    diff_t   tx_reg;
    diff_t   ty_reg;
    sector_t sec6_reg;

    diff_t   first;
    diff_t   second;
    period_t d_base;
    period_t d_first;
    period_t d_second;
    period_t duty_a_next;
    period_t duty_b_next;
    period_t duty_c_next;
    period_t duty_a_reg;
    period_t duty_b_reg;
    period_t duty_c_reg;
    sector_t sector_reg;

    function automatic period_t clamp_duty(input diff_t t, input period_t hp);
        period_t r;
        if (t <= 0)
            r = '0;
        else if (t > diff_t'({1'b0, hp}))
            r = hp;
        else
            r = t[PeriodWidth-1:0];
        return r;
    endfunction

    // stage six: halve toward zero
    assign hp_ext   = diff_t'({1'b0, half_period});
    assign diff     = hp_ext - diff_t'(tx) - diff_t'(ty);
    assign diff_adj = diff + diff_t'(diff[DWidth-1]);

    always_ff @(posedge clk)
    begin
        if (ctl.load_s6)
        begin
            base_reg <= diff_adj >>> 1;
            tx_reg   <= diff_t'(tx);
            ty_reg   <= diff_t'(ty);
            sec6_reg <= sector_in;
        end
    end

    // stage seven
    assign first    = base_reg + tx_reg;
    assign second   = first + ty_reg;
    assign d_base   = clamp_duty(base_reg, half_period);
    assign d_first  = clamp_duty(first, half_period);
    assign d_second = clamp_duty(second, half_period);

    always_comb
    begin
        unique case (sec6_reg)
            SECTOR_1:
            begin
                duty_a_next = d_base;
                duty_b_next = d_first;
                duty_c_next = d_second;
            end
            SECTOR_2:
            begin
                duty_b_next = d_base;
                duty_a_next = d_first;
                duty_c_next = d_second;
            end
            SECTOR_3:
            begin
                duty_b_next = d_base;
                duty_c_next = d_first;
                duty_a_next = d_second;
            end
            SECTOR_4:
            begin
                duty_c_next = d_base;
                duty_b_next = d_first;
                duty_a_next = d_second;
            end
            SECTOR_5:
            begin
                duty_c_next = d_base;
                duty_a_next = d_first;
                duty_b_next = d_second;
            end
            default:
            begin
                duty_a_next = d_base;
                duty_c_next = d_first;
                duty_b_next = d_second;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_s7)
        begin
            duty_a_reg <= duty_a_next;
            duty_b_reg <= duty_b_next;
            duty_c_reg <= duty_c_next;
            sector_reg <= sec6_reg;
        end
    end

    assign duty_a = duty_a_reg;
    assign duty_b = duty_b_reg;
    assign duty_c = duty_c_reg;
    assign sector = sector_reg;

endmodule

// ===== design/space_vector_pwm_timing_unit.sv =====
// top level of the space vector pwm timing unit: config register, pipeline control, stages
//
//  channel   direction  handshake                     payload
//  cfg       in         cfg_valid / cfg_ready         cfg_data = half_period
//  s_axis    in         s_axis_tvalid / tready        tdata = alpha_in, beta_in
//  m_axis    out        m_axis_tvalid / tready        tdata = duty_a, duty_b, duty_c, sector
//
// seven register stages lie between input transfer and output valid
// one transfer per cycle sustained while m_axis_tready stays high
// each stage holds its item only while the next stage is full and stalled, so bubbles close up
// reset clears the valid bits and loads half_period with 10000; payload registers are not reset
// cfg_ready is always high; writes are expected only while the pipeline is empty
module space_vector_pwm_timing_unit
    import svpwm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [PeriodWidth-1:0]  cfg_data,       // half_period
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [InDataWidth-1:0]  s_axis_tdata,   // alpha_in, beta_in
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OutDataWidth-1:0] m_axis_tdata    // duty_a, duty_b, duty_c, sector, zero pad
);

    period_t               half_period_reg;
    logic [NumStages-1:0]  valid_reg;
    logic [NumStages-1:0]  valid_next;
    logic [NumStages-1:0]  valid_in;
    logic [NumStages:0]    ready;
    pipe_ctl_t             ctl;

    logic [CompWidth-1:0]  alpha_in;
    logic [CompWidth-1:0]  beta_in;
    sum_t                  x_sum;
    sum_t                  y_sum;
    sector_t               sec2;
    sector_t               sec3_reg;
    sector_t               sec4_reg;
    sector_t               sec5_reg;
    ontime_t               tx;
    ontime_t               ty;
    period_t               duty_a;
    period_t               duty_b;
    period_t               duty_c;
    sector_t               sector_out;

    // config register, one write per transfer
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_period_reg <= HalfPeriodReset;
        else if (cfg_valid && cfg_ready)
            half_period_reg <= cfg_data;
    end

    // stage k may load when it is empty or its contents move on this cycle
    always_comb
    begin
        ready[NumStages] = m_axis_tready;
        for (int k = NumStages - 1; k >= 0; k--)
            ready[k] = !valid_reg[k] || ready[k+1];
    end

    assign valid_in   = {valid_reg[NumStages-2:0], s_axis_tvalid};
    assign valid_next = (ready[NumStages-1:0] & valid_in) | (~ready[NumStages-1:0] & valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign ctl.load_s1 = ready[0];
    assign ctl.load_s2 = ready[1];
    assign ctl.load_s3 = ready[2];
    assign ctl.load_s4 = ready[3];
    assign ctl.load_s5 = ready[4];
    assign ctl.load_s6 = ready[5];
    assign ctl.load_s7 = ready[6];

    assign s_axis_tready = ready[0];
    assign m_axis_tvalid = valid_reg[NumStages-1];

    // input unpacking, alpha in the low half
    assign alpha_in = s_axis_tdata[CompWidth-1:0];
    assign beta_in  = s_axis_tdata[2*CompWidth-1:CompWidth];

    // stages one and two
    svpwm_sector u_sector (
        .clk      (clk),
        .ctl      (ctl),
        .alpha_in (alpha_in),
        .beta_in  (beta_in),
        .x_sum    (x_sum),
        .y_sum    (y_sum),
        .sector   (sec2)
    );

    // stages three to five, one lane per on-time
    svpwm_ontime u_ontime_x (
        .clk         (clk),
        .ctl         (ctl),
        .sum_in      (x_sum),
        .half_period (half_period_reg),
        .t_out       (tx)
    );

    svpwm_ontime u_ontime_y (
        .clk         (clk),
        .ctl         (ctl),
        .sum_in      (y_sum),
        .half_period (half_period_reg),
        .t_out       (ty)
    );

    // sector travels alongside the on-time lanes
    always_ff @(posedge clk)
    begin
        if (ctl.load_s3)
            sec3_reg <= sec2;
        if (ctl.load_s4)
            sec4_reg <= sec3_reg;
        if (ctl.load_s5)
            sec5_reg <= sec4_reg;
    end

    // stages six and seven, stage seven is the output register
    svpwm_phase u_phase (
        .clk         (clk),
        .ctl         (ctl),
        .tx          (tx),
        .ty          (ty),
        .sector_in   (sec5_reg),
        .half_period (half_period_reg),
        .duty_a      (duty_a),
        .duty_b      (duty_b),
        .duty_c      (duty_c),
        .sector      (sector_out)
    );

    assign m_axis_tdata = OutDataWidth'({sector_out, duty_c, duty_b, duty_a});

    // an accepted transfer always lands in stage one
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[0])
        else $error("accepted input not captured in stage one");

    // back-pressure at the input only when every stage is occupied
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&valid_reg))
        else $error("input stalled with a bubble in the pipeline");

    // in sector one the phases rise a, b, c
    a_sector1_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && sector_out == SECTOR_1) |-> (duty_a <= duty_b && duty_b <= duty_c))
        else $error("sector one phase order broken");

    // in sector four the phases rise c, b, a
    a_sector4_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && sector_out == SECTOR_4) |-> (duty_c <= duty_b && duty_b <= duty_a))
        else $error("sector four phase order broken");

endmodule

// ===== dv/svpwm_timing_checker.sv =====
// checker for the space vector pwm timing unit: watches all channels, predicts and compares
module svpwm_timing_checker
    import svpwm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [PeriodWidth-1:0]  cfg_data,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [InDataWidth-1:0]  s_axis_tdata,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OutDataWidth-1:0] m_axis_tdata,
    output int                      fail_count,
    output int                      outstanding,
    output int                      results_checked
);

    typedef struct {
        period_t duty_a;
        period_t duty_b;
        period_t duty_c;
        sector_t sector;
    } phase_timing_t;

    phase_timing_t expected_timings[$];
    period_t       half_period;

    // coefficient sum times half period, magnitude truncated so the result rounds toward zero
    function automatic longint scaled_on_time(input longint coeff_sum, input longint period);
        longint mag;
        mag = (coeff_sum < 0) ? -coeff_sum : coeff_sum;
        mag = (mag * period) >> ProdShift;
        return (coeff_sum < 0) ? -mag : mag;
    endfunction

    function automatic period_t clamp_to_period(input longint t, input longint period);
        if (t <= 0)
            return '0;
        if (t > period)
            return period_t'(period);
        return period_t'(t);
    endfunction

    function automatic phase_timing_t predict_phase_timing(
        input logic signed [CompWidth-1:0] alpha,
        input logic signed [CompWidth-1:0] beta,
        input period_t                     period
    );
        longint        a;
        longint        b1;
        longint        b2;
        longint        hp;
        longint        tx;
        longint        ty;
        longint        base;
        longint        first;
        longint        second;
        longint        ta;
        longint        tb;
        longint        tc;
        sector_t       sec;
        phase_timing_t res;

        a  = longint'(alpha) * 65536;
        b1 = longint'(beta) * 37837;
        b2 = longint'(beta) * 75674;
        hp = longint'(period);

        // quadrant first, then alpha against beta/sqrt3
        if (beta >= 0)
        begin
            if (alpha >= 0)
                sec = (b1 > a) ? SECTOR_2 : SECTOR_1;
            else
                sec = (-b1 > a) ? SECTOR_3 : SECTOR_2;
        end
        else
        begin
            if (alpha >= 0)
                sec = (-b1 > a) ? SECTOR_5 : SECTOR_6;
            else
                sec = (b1 > a) ? SECTOR_4 : SECTOR_5;
        end

        case (sec)
            SECTOR_1:
            begin
                tx = scaled_on_time(a - b1, hp);
                ty = scaled_on_time(b2, hp);
            end
            SECTOR_2:
            begin
                tx = scaled_on_time(-a + b1, hp);
                ty = scaled_on_time(a + b1, hp);
            end
            SECTOR_3:
            begin
                tx = scaled_on_time(b2, hp);
                ty = scaled_on_time(-a - b1, hp);
            end
            SECTOR_4:
            begin
                tx = scaled_on_time(-b2, hp);
                ty = scaled_on_time(-a + b1, hp);
            end
            SECTOR_5:
            begin
                tx = scaled_on_time(-a - b1, hp);
                ty = scaled_on_time(a - b1, hp);
            end
            default:
            begin
                tx = scaled_on_time(a + b1, hp);
                ty = scaled_on_time(-b2, hp);
            end
        endcase

        // sv division truncates toward zero
        base   = (hp - tx - ty) / 2;
        first  = base + tx;
        second = first + ty;

        case (sec)
            SECTOR_1:
            begin
                ta = base;   tb = first;  tc = second;
            end
            SECTOR_2:
            begin
                tb = base;   ta = first;  tc = second;
            end
            SECTOR_3:
            begin
                tb = base;   tc = first;  ta = second;
            end
            SECTOR_4:
            begin
                tc = base;   tb = first;  ta = second;
            end
            SECTOR_5:
            begin
                tc = base;   ta = first;  tb = second;
            end
            default:
            begin
                ta = base;   tc = first;  tb = second;
            end
        endcase

        res.duty_a = clamp_to_period(ta, hp);
        res.duty_b = clamp_to_period(tb, hp);
        res.duty_c = clamp_to_period(tc, hp);
        res.sector = sec;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        phase_timing_t          want;
        period_t                got_a;
        period_t                got_b;
        period_t                got_c;
        logic [SectorWidth-1:0] got_sector;

        if (!rst_n)
        begin
            expected_timings.delete();
            half_period     = HalfPeriodReset;
            fail_count      = 0;
            outstanding     = 0;
            results_checked = 0;
        end
        else
        begin
            // results leave before this edge's input can reach the output
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_a      = m_axis_tdata[PeriodWidth-1:0];
                got_b      = m_axis_tdata[2*PeriodWidth-1:PeriodWidth];
                got_c      = m_axis_tdata[3*PeriodWidth-1:2*PeriodWidth];
                got_sector = m_axis_tdata[3*PeriodWidth+SectorWidth-1:3*PeriodWidth];
                if (expected_timings.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with nothing expected: a=%0d b=%0d c=%0d sector=%0d",
                             $time, got_a, got_b, got_c, got_sector);
                end
                else
                begin
                    want = expected_timings.pop_front();
                    results_checked++;
                    if (got_a !== want.duty_a || got_b !== want.duty_b ||
                        got_c !== want.duty_c || got_sector !== want.sector)
                    begin
                        fail_count++;
                        $display(
                            "%0t: exp a=%0d b=%0d c=%0d sec=%0d, got a=%0d b=%0d c=%0d sec=%0d",
                            $time, want.duty_a, want.duty_b, want.duty_c, want.sector,
                            got_a, got_b, got_c, got_sector);
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                expected_timings.push_back(predict_phase_timing(
                    s_axis_tdata[CompWidth-1:0],
                    s_axis_tdata[2*CompWidth-1:CompWidth],
                    half_period));

            if (cfg_valid && cfg_ready)
                half_period = cfg_data;

            outstanding = expected_timings.size();
        end
    end

endmodule

// ===== dv/tb_space_vector_pwm_timing_unit.sv =====
// testbench top for the space vector pwm timing unit: stimulus, handshake idling, verdict
module tb_space_vector_pwm_timing_unit;

    import svpwm_pkg::*;

    localparam int NumPhases      = 6;
    localparam int ItemsPerPhase  = 250;
    localparam int ClockPeriod    = 12;
    localparam int TimeoutCycles  = 200000;
    localparam int DrainCycles    = 20;

    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    cfg_valid     = 1'b0;
    logic                    cfg_ready;
    logic [PeriodWidth-1:0]  cfg_data      = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [InDataWidth-1:0]  s_axis_tdata  = '0;     // alpha_in, beta_in
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OutDataWidth-1:0] m_axis_tdata;           // duty_a, duty_b, duty_c, sector, zero pad

    int fail_count;
    int outstanding;
    int results_checked;

    // idle percentages per cycle for each side of the stream
    int send_idle_pct = 23;
    int recv_idle_pct = 54;
    int items_sent    = 0;

    space_vector_pwm_timing_unit dut (.*);

    svpwm_timing_checker checker_inst (.*);

    always
    begin
        #(ClockPeriod / 2) clk = 1'b1;
        #(ClockPeriod / 2) clk = 1'b0;
    end

    // receiver: ready decided fresh every cycle
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // one input transfer; tready is read mid-cycle so the edge outcome is known beforehand
    task automatic send_item(input int alpha, input int beta);
        logic fire;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= InDataWidth'({CompWidth'(beta), CompWidth'(alpha)});
        do
        begin
            @(negedge clk);
            fire = s_axis_tready;
            @(posedge clk);
        end
        while (!fire);
        items_sent++;
    endtask

    // the four alpha values around the sector edge for this beta (both alpha signs)
    task automatic send_sector_edges(input int beta);
        longint edge_alpha;
        edge_alpha = (longint'(beta) * 37837) >>> 16;
        send_item(int'(edge_alpha), beta);
        send_item(int'(edge_alpha) + 1, beta);
        send_item(-int'(edge_alpha), beta);
        send_item(-int'(edge_alpha) - 1, beta);
    endtask

    task automatic send_random_item();
        int unsigned pick;
        int          alpha;
        int          beta;
        longint      edge_alpha;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            // full range, every bit of both components
            alpha = int'($signed(CompWidth'($urandom)));
            beta  = int'($signed(CompWidth'($urandom)));
        end
        else if (pick < 80)
        begin
            // hug a sector edge from either side
            beta       = int'($signed(CompWidth'($urandom)));
            edge_alpha = (longint'(beta) * 37837) >>> 16;
            alpha      = int'(edge_alpha) + int'($urandom_range(4)) - 2;
            if ($urandom_range(1) == 1)
                alpha = -alpha;
        end
        else if (pick < 90)
        begin
            // tiny vectors: short on-times, base near half the period
            alpha = int'($urandom_range(255)) - 128;
            beta  = int'($urandom_range(255)) - 128;
        end
        else
        begin
            // axis-aligned and near-zero beta, crossing the quadrant boundaries
            alpha = int'($signed(CompWidth'($urandom)));
            beta  = int'($urandom_range(2)) - 1;
        end
        send_item(alpha, beta);
    endtask

    // results drained: every input produced exactly one result, so the pipe is empty
    task automatic wait_drained();
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic write_half_period(input int value);
        logic fire;
        cfg_valid <= 1'b1;
        cfg_data  <= PeriodWidth'(value);
        do
        begin
            @(negedge clk);
            fire = cfg_ready;
            @(posedge clk);
        end
        while (!fire);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned period_plan [NumPhases];
        int          hp_value;

        // reset value first, then both extremes, zero, a random value and mid scale
        period_plan = '{10000, 65535, 1, 0, 0, 32768};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, unit steps, over-modulation corners, sector edges
        send_item(0, 0);
        send_item(32767, 0);
        send_item(-32768, 0);
        send_item(0, 32767);
        send_item(0, -32768);
        send_item(32767, 32767);
        send_item(-32768, -32768);
        send_item(32767, -32768);
        send_item(-32768, 32767);
        send_item(1, 0);
        send_item(-1, 0);
        send_item(0, 1);
        send_item(0, -1);
        send_sector_edges(20000);
        send_sector_edges(-20000);

        for (int phase = 0; phase < NumPhases; phase++)
        begin
            // first the sender idles lightly, then the receiver, then neither
            if (phase == 2)
            begin
                send_idle_pct = 54;
                recv_idle_pct = 23;
            end
            else if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            if (phase != 0)
            begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
                hp_value = (phase == 4) ? int'($urandom_range(65534, 2)) : int'(period_plan[phase]);
                write_half_period(hp_value);
            end

            repeat (ItemsPerPhase) send_random_item();
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        // catch any stray result after the last expected one
        repeat (DrainCycles) @(posedge clk);

        $display("covered %0d input transfers and %0d checked results", items_sent,
                 results_checked);
        $display("half periods 10000, 65535, 1, 0, random and 32768; three idle mixes");
        if (fail_count == 0 && outstanding == 0)
            $display("space_vector_pwm_timing_unit test passed");
        else
            $display("space_vector_pwm_timing_unit test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(ClockPeriod * TimeoutCycles);
        $display("space_vector_pwm_timing_unit test failed");
        $finish;
    end

endmodule

// ===== space_vector_pwm_timing_unit.f =====
design/svpwm_pkg.sv
design/svpwm_sector.sv
design/svpwm_ontime.sv
design/svpwm_phase.sv
design/space_vector_pwm_timing_unit.sv
dv/svpwm_timing_checker.sv
dv/tb_space_vector_pwm_timing_unit.sv
